### rtl/core/ppk_pkg.sv
// Package for the spectrum peak picker: widths, reset values, register
// indexes and the payload and config structs. No dependencies.
package ppk_pkg;

  localparam int PEAK_COUNT = 3;
  localparam int MAG_BITS   = 32;
  localparam int IDX_W      = (PEAK_COUNT > 1) ? $clog2(PEAK_COUNT) : 1;

  localparam int BIN_W   = 16;
  localparam int MAG_W   = 32;
  localparam int RATE_W  = 18;
  localparam int SHIFT_W = 5;
  localparam int FREQ_W  = 18;
  localparam int RANK_W  = 2;
  localparam int PROD_W  = BIN_W + RATE_W;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 18;

  localparam logic [RATE_W-1:0]  SAMPLE_RATE_RST = RATE_W'(44100);
  localparam logic [SHIFT_W-1:0] FFT_LOG2_RST    = SHIFT_W'(12);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SAMPLE_RATE = 1'b0,
    CFG_FFT_LOG2    = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [RATE_W-1:0]  sample_rate_hz;
    logic [SHIFT_W-1:0] fft_size_log2;
  } cfg_t;

  typedef struct packed {
    logic [BIN_W-1:0] bin_index;
    logic [MAG_W-1:0] magnitude;
    logic             last_bin;
  } in_item_t;

  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic [FREQ_W-1:0] frequency_hz;
    logic [MAG_W-1:0]  peak_magnitude;
    logic              last_result;
  } out_item_t;

  typedef struct packed {
    logic [FREQ_W-1:0]   freq;
    logic [MAG_BITS-1:0] mag;
  } peak_t;

  // One bin with its frequency worked out, on its way into the store
  typedef struct packed {
    logic                valid;
    logic [FREQ_W-1:0]   freq;
    logic [MAG_BITS-1:0] mag;
    logic                last;
  } bin_t;

endpackage

### rtl/core/ppk_freq_pipe.sv
// Input register and frequency pipeline: bin index times sample rate,
// then shift and saturate. Depends on ppk_pkg.
module ppk_freq_pipe (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ppk_pkg::cfg_t     cfg_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  ppk_pkg::in_item_t in_data_i,
  output ppk_pkg::bin_t     bin_o,
  input  logic              take_i
);

  logic                        s1_valid_q;
  ppk_pkg::in_item_t           s1_item_q;
  logic                        s2_valid_q;
  logic [ppk_pkg::PROD_W-1:0]  s2_prod_q;
  logic [ppk_pkg::MAG_BITS-1:0] s2_mag_q;
  logic                        s2_last_q;
  logic                        s1_adv;
  logic                        s2_adv;
  logic [ppk_pkg::PROD_W-1:0]  prod_d;
  logic [ppk_pkg::PROD_W-1:0]  shifted;

  assign s2_adv     = !s2_valid_q || take_i;
  assign s1_adv     = !s1_valid_q || s2_adv;
  assign in_stall_o = !s1_adv;

  assign prod_d = ppk_pkg::PROD_W'(s1_item_q.bin_index) *
                  ppk_pkg::PROD_W'(cfg_i.sample_rate_hz);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_adv) s1_valid_q <= in_valid_i;
      if (s2_adv) s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && in_valid_i) s1_item_q <= in_data_i;
    if (s2_adv && s1_valid_q) begin
      s2_prod_q <= prod_d;
      s2_mag_q  <= s1_item_q.magnitude[ppk_pkg::MAG_BITS-1:0];
      s2_last_q <= s1_item_q.last_bin;
    end
  end

  // saturate when anything is left above the frequency field
  assign shifted     = s2_prod_q >> cfg_i.fft_size_log2;
  assign bin_o.valid = s2_valid_q;
  assign bin_o.freq  = (|shifted[ppk_pkg::PROD_W-1:ppk_pkg::FREQ_W]) ?
                       {ppk_pkg::FREQ_W{1'b1}} : shifted[ppk_pkg::FREQ_W-1:0];
  assign bin_o.mag   = s2_mag_q;
  assign bin_o.last  = s2_last_q;

endmodule

### rtl/core/ppk_rank_store.sv
// Ranked peak store: one bin per cycle with parallel compares, but a last bin
// waits for a free output buffer to hand it a snapshot. Depends on ppk_pkg.
module ppk_rank_store (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  ppk_pkg::bin_t bin_i,
  output logic          take_o,
  input  logic          buf_free_i,
  output logic          snap_load_o,
  output ppk_pkg::peak_t [ppk_pkg::PEAK_COUNT-1:0] snap_o
);

  ppk_pkg::peak_t [ppk_pkg::PEAK_COUNT-1:0] peak_q;
  ppk_pkg::peak_t [ppk_pkg::PEAK_COUNT-1:0] peak_ins;
  logic [ppk_pkg::PEAK_COUNT-1:0]           gt;
  logic                                     fire;

  assign take_o      = !bin_i.last || buf_free_i;
  assign fire        = bin_i.valid && take_o;
  assign snap_load_o = fire && bin_i.last;
  assign snap_o      = peak_ins;

  // Store stays sorted, so gt is a run of ones from the first rank beaten down
  always_comb begin
    for (int k = 0; k < ppk_pkg::PEAK_COUNT; k++) begin
      gt[k] = bin_i.mag > peak_q[k].mag;
    end
    for (int k = 0; k < ppk_pkg::PEAK_COUNT; k++) begin
      if (!gt[k]) begin
        peak_ins[k] = peak_q[k];
      end else if (k == 0) begin
        peak_ins[k].freq = bin_i.freq;
        peak_ins[k].mag  = bin_i.mag;
      end else if (!gt[k-1]) begin
        peak_ins[k].freq = bin_i.freq;
        peak_ins[k].mag  = bin_i.mag;
      end else begin
        peak_ins[k] = peak_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_q <= '0;
    end else if (fire) begin
      // drop the frame once it is handed over
      peak_q <= bin_i.last ? '0 : peak_ins;
    end
  end

`ifndef SYNTHESIS
  for (genvar g = 1; g < ppk_pkg::PEAK_COUNT; g++) begin : g_chk
    a_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
      peak_q[g].mag <= peak_q[g-1].mag)
      else $error("peak store out of order");
  end
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    snap_load_o |=> peak_q == '0)
    else $error("store not cleared after frame");
  a_gt_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bin_i.valid |->
      (gt[ppk_pkg::PEAK_COUNT-1] || !gt[0] || bin_i.mag > peak_q[0].mag))
    else $error("compare vector inconsistent");
`endif

endmodule

### rtl/core/ppk_out_buf.sv
// Result buffer: holds one frame's peaks and sends them in rank order.
// Depends on ppk_pkg.
module ppk_out_buf (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  ppk_pkg::peak_t [ppk_pkg::PEAK_COUNT-1:0] snap_i,
  output logic               free_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ppk_pkg::out_item_t out_data_o
);

  ppk_pkg::peak_t [ppk_pkg::PEAK_COUNT-1:0] buf_q;
  logic                                     valid_q;
  logic [ppk_pkg::IDX_W-1:0]                ptr_q;
  logic                                     xfer;
  logic                                     at_last;

  assign at_last = ptr_q == ppk_pkg::IDX_W'(ppk_pkg::PEAK_COUNT - 1);
  assign xfer    = valid_q && !out_stall_i;
  assign free_o  = !valid_q || (xfer && at_last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      ptr_q   <= '0;
    end else if (load_i) begin
      valid_q <= 1'b1;
      ptr_q   <= '0;
    end else if (xfer) begin
      // advance through the ranks, release after the lowest one
      valid_q <= !at_last;
      ptr_q   <= at_last ? '0 : ptr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) buf_q <= snap_i;
  end

  assign out_valid_o                = valid_q;
  assign out_data_o.rank            = ppk_pkg::RANK_W'(ptr_q);
  assign out_data_o.frequency_hz    = buf_q[ptr_q].freq;
  assign out_data_o.peak_magnitude  = ppk_pkg::MAG_W'(buf_q[ptr_q].mag);
  assign out_data_o.last_result     = at_last;

`ifndef SYNTHESIS
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> free_o)
    else $error("frame loaded over pending results");
  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> ptr_q <= ppk_pkg::IDX_W'(ppk_pkg::PEAK_COUNT - 1))
    else $error("rank pointer out of range");
  a_next_rank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (xfer && !at_last && !load_i) |=> valid_q && ptr_q == $past(ptr_q) + 1'b1)
    else $error("rank sequence broken");
`endif

endmodule

### rtl/core/spectrum_top3_peak_picker_top.sv
// Top level of the spectrum peak picker: config registers and the three
// stages. Depends on ppk_pkg, ppk_freq_pipe, ppk_rank_store, ppk_out_buf.
// One bin per cycle in, a frame's three results one per cycle out, each side
// unless stalled. A last bin goes from the input register to the product
// stage and waits there until the previous frame's results are out. Reset:
// sample rate 44100, fft log2 12, peak store all zeros.
module spectrum_top3_peak_picker_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [ppk_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [ppk_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  ppk_pkg::in_item_t                  in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output ppk_pkg::out_item_t                 out_data_o
);

  ppk_pkg::cfg_t  cfg_q;
  ppk_pkg::bin_t  bin;
  ppk_pkg::peak_t [ppk_pkg::PEAK_COUNT-1:0] snap;
  logic           take;
  logic           buf_free;
  logic           snap_load;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sample_rate_hz <= ppk_pkg::SAMPLE_RATE_RST;
      cfg_q.fft_size_log2  <= ppk_pkg::FFT_LOG2_RST;
    end else if (cfg_valid_i) begin
      case (ppk_pkg::cfg_reg_e'(cfg_index_i))
        ppk_pkg::CFG_SAMPLE_RATE:
          cfg_q.sample_rate_hz <= cfg_data_i[ppk_pkg::RATE_W-1:0];
        ppk_pkg::CFG_FFT_LOG2:
          cfg_q.fft_size_log2  <= cfg_data_i[ppk_pkg::SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  ppk_freq_pipe u_freq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .bin_o      (bin),
    .take_i     (take)
  );

  ppk_rank_store u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .bin_i       (bin),
    .take_o      (take),
    .buf_free_i  (buf_free),
    .snap_load_o (snap_load),
    .snap_o      (snap)
  );

  ppk_out_buf u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (snap_load),
    .snap_i      (snap),
    .free_o      (buf_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

### bench/peak_pick_check.sv
// Scoreboard for the spectrum peak picker: follows the rate and shift registers,
// predicts the three ranked peaks of every frame and compares each result transfer.
// Depends on ppk_pkg.
module peak_pick_check (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [ppk_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ppk_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  ppk_pkg::in_item_t              in_data_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  ppk_pkg::out_item_t             out_data_i,
  output int                             mismatches_o,
  output int                             pending_o,
  output int                             bins_o,
  output int                             results_o
);

  logic [ppk_pkg::RATE_W-1:0]  rate_q;
  logic [ppk_pkg::SHIFT_W-1:0] shift_q;
  logic [ppk_pkg::MAG_W-1:0]   top_mag  [ppk_pkg::PEAK_COUNT];
  logic [ppk_pkg::FREQ_W-1:0]  top_freq [ppk_pkg::PEAK_COUNT];
  ppk_pkg::out_item_t          peaks_due [$];

  function automatic logic [ppk_pkg::FREQ_W-1:0] bin_freq(
    logic [ppk_pkg::BIN_W-1:0] idx);
    logic [ppk_pkg::PROD_W-1:0] scaled;
    scaled = (ppk_pkg::PROD_W'(idx) * ppk_pkg::PROD_W'(rate_q)) >> shift_q;
    // saturate anything that does not fit the frequency field
    return (scaled > ppk_pkg::PROD_W'({ppk_pkg::FREQ_W{1'b1}})) ?
           {ppk_pkg::FREQ_W{1'b1}} : scaled[ppk_pkg::FREQ_W-1:0];
  endfunction

  task automatic clear_peaks();
    for (int k = 0; k < ppk_pkg::PEAK_COUNT; k++) begin
      top_mag[k]  = '0;
      top_freq[k] = '0;
    end
  endtask

  task automatic take_bin(ppk_pkg::in_item_t b);
    logic               placed;
    ppk_pkg::out_item_t due;
    placed = 1'b0;
    for (int k = 0; k < ppk_pkg::PEAK_COUNT; k++) begin
      if (!placed && b.magnitude > top_mag[k]) begin
        // shift lower ranks down, the last one drops out
        for (int j = ppk_pkg::PEAK_COUNT - 1; j > k; j--) begin
          top_mag[j]  = top_mag[j-1];
          top_freq[j] = top_freq[j-1];
        end
        top_mag[k]  = b.magnitude;
        top_freq[k] = bin_freq(b.bin_index);
        placed      = 1'b1;
      end
    end
    if (b.last_bin) begin
      for (int k = 0; k < ppk_pkg::PEAK_COUNT; k++) begin
        due.rank           = ppk_pkg::RANK_W'(k);
        due.frequency_hz   = top_freq[k];
        due.peak_magnitude = top_mag[k];
        due.last_result    = (k == ppk_pkg::PEAK_COUNT - 1);
        peaks_due.push_back(due);
      end
      clear_peaks();
    end
    bins_o++;
  endtask

  task automatic check_result(ppk_pkg::out_item_t got);
    ppk_pkg::out_item_t want;
    results_o++;
    if (peaks_due.size() == 0) begin
      mismatches_o++;
      $display("%0t: unexpected result: expected none, actual rank %0d freq %0d mag %h last %b",
               $time, got.rank, got.frequency_hz, got.peak_magnitude, got.last_result);
    end else begin
      want = peaks_due.pop_front();
      if (got.rank !== want.rank) begin
        mismatches_o++;
        $display("%0t: rank: expected %0d, actual %0d", $time, want.rank, got.rank);
      end
      if (got.frequency_hz !== want.frequency_hz) begin
        mismatches_o++;
        $display("%0t: frequency_hz (rank %0d): expected %0d, actual %0d",
                 $time, want.rank, want.frequency_hz, got.frequency_hz);
      end
      if (got.peak_magnitude !== want.peak_magnitude) begin
        mismatches_o++;
        $display("%0t: peak_magnitude (rank %0d): expected %h, actual %h",
                 $time, want.rank, want.peak_magnitude, got.peak_magnitude);
      end
      if (got.last_result !== want.last_result) begin
        mismatches_o++;
        $display("%0t: last_result (rank %0d): expected %b, actual %b",
                 $time, want.rank, want.last_result, got.last_result);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q  = ppk_pkg::SAMPLE_RATE_RST;
      shift_q = ppk_pkg::FFT_LOG2_RST;
      clear_peaks();
      peaks_due.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          ppk_pkg::CFG_SAMPLE_RATE: rate_q  = cfg_data_i[ppk_pkg::RATE_W-1:0];
          ppk_pkg::CFG_FFT_LOG2:    shift_q = cfg_data_i[ppk_pkg::SHIFT_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) check_result(out_data_i);
      if (in_valid_i && !in_stall_i) take_bin(in_data_i);
    end
    pending_o = peaks_due.size();
  end

endmodule

### bench/spectrum_top3_peak_picker_top_tb.sv
// Testbench top for the spectrum peak picker: drives register writes and bin
// frames with random bursts and output stalls, and reports the verdict.
// Depends on ppk_pkg, spectrum_top3_peak_picker_top and peak_pick_check.
module spectrum_top3_peak_picker_top_tb;

  localparam int NUM_SETTINGS = 8;
  localparam int BINS_PER_SETTING = 22;
  localparam int LONG_HOLD_CYCLES = 90;

  typedef enum int {RX_FLOW, RX_RANDOM, RX_HEAVY} rx_mode_e;

  logic                           clk_i       = 1'b0;
  logic                           rst_ni      = 1'b0;
  logic                           cfg_valid_i = 1'b0;
  logic                           cfg_ready_o;
  logic [ppk_pkg::CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [ppk_pkg::CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic                           in_valid_i  = 1'b0;
  logic                           in_stall_o;
  ppk_pkg::in_item_t              in_data_i   = '0;
  logic                           out_valid_o;
  logic                           out_stall_i = 1'b0;
  ppk_pkg::out_item_t             out_data_o;

  int mismatches, pending, bins_seen, results_seen;
  int sent        = 0;
  int burst_left  = 0;
  int holds_asked = 0;
  int holds_done  = 0;
  bit gapless     = 1'b0;

  logic [ppk_pkg::RATE_W-1:0]  rate_set  [NUM_SETTINGS];
  logic [ppk_pkg::SHIFT_W-1:0] shift_set [NUM_SETTINGS];

  spectrum_top3_peak_picker_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  peak_pick_check peak_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_i   (out_data_o),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .bins_o       (bins_seen),
    .results_o    (results_seen)
  );

  always #2 clk_i = ~clk_i;

  initial begin
    #400000;
    $display("Verification failed");
    $finish;
  end

  // Output side: segments of free flow, random stalls and heavy stalls, plus
  // long holds on request from the stimulus.
  initial begin : receiver
    rx_mode_e rx_mode;
    int       seg_left;
    int       hold_left;
    rx_mode   = RX_FLOW;
    seg_left  = 0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (holds_asked != holds_done) begin
        holds_done++;
        hold_left = LONG_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        if (seg_left == 0) begin
          rx_mode  = rx_mode_e'($urandom_range(0, 2));
          seg_left = $urandom_range(5, 40);
        end
        seg_left--;
        case (rx_mode)
          RX_FLOW:   out_stall_i <= 1'b0;
          RX_RANDOM: out_stall_i <= ($urandom_range(0, 99) < 35);
          RX_HEAVY:  out_stall_i <= ($urandom_range(0, 99) < 80);
          default:   out_stall_i <= 1'b0;
        endcase
      end
    end
  end

  task automatic set_rate_and_shift(logic [ppk_pkg::RATE_W-1:0] rate,
                                    logic [ppk_pkg::SHIFT_W-1:0] shift);
    logic [ppk_pkg::CFG_DATA_W-ppk_pkg::SHIFT_W-1:0] junk;
    junk = (ppk_pkg::CFG_DATA_W - ppk_pkg::SHIFT_W)'($urandom());
    cfg_valid_i <= 1'b1;
    cfg_index_i <= ppk_pkg::CFG_SAMPLE_RATE;
    cfg_data_i  <= rate;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    // upper data bits are ignored by the shift register
    cfg_index_i <= ppk_pkg::CFG_FFT_LOG2;
    cfg_data_i  <= {junk, shift};
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_bin(logic [ppk_pkg::BIN_W-1:0] idx, logic [ppk_pkg::MAG_W-1:0] mag,
                          logic last);
    ppk_pkg::in_item_t b;
    int                gap;
    b.bin_index = idx;
    b.magnitude = mag;
    b.last_bin  = last;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 10);
      gap = gapless ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent++;
  endtask

  function automatic logic [ppk_pkg::MAG_W-1:0] pick_mag();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return ppk_pkg::MAG_W'($urandom_range(0, 3)) << 16;  // plenty of ties
      default: return $urandom();
    endcase
  endfunction

  task automatic random_frame(int n_bins);
    logic [ppk_pkg::BIN_W-1:0] idx;
    bit                        walk;
    idx  = ppk_pkg::BIN_W'($urandom());
    walk = 1'($urandom_range(0, 1));
    for (int i = 0; i < n_bins; i++) begin
      send_bin(walk ? idx + ppk_pkg::BIN_W'(i) : ppk_pkg::BIN_W'($urandom()), pick_mag(),
               i == n_bins - 1);
    end
  endtask

  // Hold off until every expected result is out, then let the pipe settle.
  task automatic drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  initial begin : stimulus
    int target;
    rate_set[0] = 18'd44100;   shift_set[0] = 5'd12;
    rate_set[1] = 18'd0;       shift_set[1] = 5'd5;
    rate_set[2] = 18'h3FFFF;   shift_set[2] = 5'd0;
    rate_set[3] = 18'h3FFFF;   shift_set[3] = 5'd31;
    rate_set[4] = 18'd1;       shift_set[4] = 5'd4;
    rate_set[5] = 18'd200000;  shift_set[5] = 5'd16;
    rate_set[6] = ppk_pkg::RATE_W'($urandom_range(1, 200000));
    shift_set[6] = ppk_pkg::SHIFT_W'($urandom_range(0, 31));
    rate_set[7] = ppk_pkg::RATE_W'($urandom_range(1, 262143));
    shift_set[7] = ppk_pkg::SHIFT_W'($urandom_range(0, 31));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int p = 0; p < NUM_SETTINGS; p++) begin
      set_rate_and_shift(rate_set[p], shift_set[p]);
      if (p == 0) begin
        // zero magnitude alone: every rank stays empty
        send_bin(16'h0000, 32'h0000_0000, 1'b1);
        // ties: equal to a kept value enters only below it
        send_bin(16'hFFFF, 32'hFFFF_FFFF, 1'b0);
        send_bin(16'h0001, 32'h0001_0000, 1'b0);
        send_bin(16'h0002, 32'h0001_0000, 1'b0);
        send_bin(16'h0003, 32'h0001_0000, 1'b0);
        send_bin(16'h0004, 32'h0000_8000, 1'b1);
        // ascending
        send_bin(16'd10, 32'd1, 1'b0);
        send_bin(16'd11, 32'd2, 1'b0);
        send_bin(16'd12, 32'd3, 1'b0);
        send_bin(16'd13, 32'd4, 1'b1);
        // descending, last bin lands in the middle
        send_bin(16'd20, 32'hC000_0000, 1'b0);
        send_bin(16'd21, 32'h8000_0000, 1'b0);
        send_bin(16'd22, 32'h4000_0000, 1'b0);
        send_bin(16'd23, 32'h2000_0000, 1'b0);
        send_bin(16'd24, 32'h9000_0000, 1'b1);
        // short frame with a zero last bin
        send_bin(16'd30, 32'h0000_1234, 1'b0);
        send_bin(16'd31, 32'h0000_0000, 1'b1);
      end else if (p == 2) begin
        send_bin(16'hFFFF, 32'd7, 1'b0);
        send_bin(16'h0001, 32'd9, 1'b1);
      end else if (p == 5) begin
        // back up the output while frames keep coming
        holds_asked++;
        gapless = 1'b1;
        repeat (16) random_frame($urandom_range(1, 3));
        gapless = 1'b0;
      end
      target = sent + BINS_PER_SETTING;
      while (sent < target) begin
        random_frame(($urandom_range(0, 5) == 0) ? $urandom_range(9, 24)
                                                 : $urandom_range(1, 8));
        if ($urandom_range(0, 7) == 0) drain();
      end
      drain();
    end

    $display("Covered %0d bins over %0d rate/shift settings incl. zero rate, saturation,",
             bins_seen, NUM_SETTINGS);
    $display("shifts 0 and 31, ties and a long output hold; %0d peak results compared.",
             results_seen);
    if (mismatches == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
